/* hw/rtl/spa_pkg.sv */
// Package: shared types and constants for the segment pool allocator.
`default_nettype none

package spa_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [LEN_W-1:0] SEG_SIZE_RESET = 32'd1048576;

  // Command codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_NEW      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HELD     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_HELD = 3'd4;

  typedef struct packed {
    logic             command;
    logic [ID_W-1:0]  segment_id;
    logic             use_default_size;
    logic [LEN_W-1:0] requested_length;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_index;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    slot_length;
    logic [COUNT_W-1:0]  free_slots;
    logic [COUNT_W-1:0]  used_slots;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request, restart owner scan
    logic scan;    // advance owner scan
    logic commit;  // apply update, emit result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cmp_last;  // last owner entry is compared this cycle
  } ctrl_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/spa_datapath.sv */
// Datapath: owner and free-stack memories, bound bits, counters, owner scan and update.
`default_nettype none

module spa_datapath #(
  parameter int unsigned POOL_SLOTS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire spa_pkg::req_t      req_i,
  input  wire spa_pkg::ctrl_cmd_t cmd_i,
  output spa_pkg::ctrl_sts_t      sts_o,
  output spa_pkg::result_t        result_o,
  output logic                    done_o
);

  localparam int unsigned IdxW   = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CntW   = $clog2(POOL_SLOTS + 1);
  localparam int unsigned SlotW  = spa_pkg::SLOT_W;
  localparam int unsigned CountW = spa_pkg::COUNT_W;
  localparam int unsigned LenW   = spa_pkg::LEN_W;
  localparam int unsigned IdW    = spa_pkg::ID_W;

  localparam logic [CntW-1:0] FullCnt  = CntW'(POOL_SLOTS);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(POOL_SLOTS - 1);

  logic [LenW-1:0]       cfg_size_q;
  spa_pkg::req_t         req_q;
  logic [IdxW-1:0]       idx_q;
  logic                  issue_done_q;
  logic                  rd_vld_q;
  logic                  rd_last_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic [IdW-1:0]        owner_rd_q;
  logic                  bound_rd_q;
  logic                  hit_q;
  logic [IdxW-1:0]       hit_idx_q;
  logic [POOL_SLOTS-1:0] bound_q;
  logic [CntW-1:0]       free_top_q, free_top_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       low_q, low_d;
  logic [IdxW-1:0]       stack_rd_q;
  spa_pkg::result_t      result_q, result_d;
  logic                  done_q;

  logic [IdW-1:0]  owner_mem [POOL_SLOTS];
  logic [IdxW-1:0] stack_mem [POOL_SLOTS];

  logic            issue;
  logic            match;
  logic [CntW-1:0] top_m1_cnt;
  logic [IdxW-1:0] top_m1;
  logic [IdxW-1:0] pop_slot;
  logic [LenW-1:0] size;
  logic            do_bind;
  logic            do_unbind;
  logic            do_push;

  assign issue      = cmd_i.scan && !issue_done_q;
  assign match      = rd_vld_q && !hit_q && bound_rd_q &&
                      (owner_rd_q == req_q.segment_id);
  assign top_m1_cnt = free_top_q - CntW'(1);
  assign top_m1     = top_m1_cnt[IdxW-1:0];
  // Entries below the lowest stack depth ever reached still hold their reset slot.
  assign pop_slot   = (top_m1_cnt >= low_q) ? stack_rd_q : top_m1;
  assign size       = req_q.use_default_size ? cfg_size_q : req_q.requested_length;

  always_comb begin
    free_top_d = free_top_q;
    count_d    = count_q;
    do_bind    = 1'b0;
    do_unbind  = 1'b0;
    do_push    = 1'b0;
    result_d   = '0;
    if (req_q.command == spa_pkg::CMD_ALLOC) begin
      if (hit_q) begin
        result_d.slot_index  = SlotW'(hit_idx_q);
        result_d.status      = spa_pkg::ST_HELD;
        result_d.slot_length = size;
      end else if (free_top_q == '0) begin
        result_d.status = spa_pkg::ST_EMPTY;
      end else begin
        do_bind              = 1'b1;
        free_top_d           = top_m1_cnt;
        count_d              = count_q + CntW'(1);
        result_d.slot_index  = SlotW'(pop_slot);
        result_d.status      = spa_pkg::ST_NEW;
        result_d.slot_length = size;
      end
    end else begin
      if (!hit_q) begin
        result_d.status = spa_pkg::ST_NOT_HELD;
      end else begin
        do_unbind            = 1'b1;
        result_d.slot_index  = SlotW'(hit_idx_q);
        result_d.status      = spa_pkg::ST_RELEASED;
        result_d.slot_length = cfg_size_q;
        if (free_top_q != FullCnt) begin
          do_push    = 1'b1;
          free_top_d = free_top_q + CntW'(1);
        end
        if (count_q != '0) begin
          count_d = count_q - CntW'(1);
        end
      end
    end
    result_d.free_slots = CountW'(free_top_d);
    result_d.used_slots = CountW'(count_d);
    low_d = (free_top_d < low_q) ? free_top_d : low_q;
  end

  // Control and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q   <= spa_pkg::SEG_SIZE_RESET;
      idx_q        <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      rd_last_q    <= 1'b0;
      hit_q        <= 1'b0;
      bound_q      <= '0;
      free_top_q   <= FullCnt;
      count_q      <= '0;
      low_q        <= FullCnt;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_size_q <= cfg_wdata_i;
      end
      rd_vld_q  <= issue;
      rd_last_q <= issue && (idx_q == LastIdx);
      done_q    <= cmd_i.commit;
      if (cmd_i.load) begin
        idx_q        <= '0;
        issue_done_q <= 1'b0;
        hit_q        <= 1'b0;
      end else if (issue) begin
        if (idx_q == LastIdx) begin
          issue_done_q <= 1'b1;
        end else begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
      if (match) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        free_top_q <= free_top_d;
        count_q    <= count_d;
        low_q      <= low_d;
        if (do_bind) begin
          bound_q[pop_slot] <= 1'b1;
        end
        if (do_unbind) begin
          bound_q[hit_idx_q] <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    rd_idx_q   <= idx_q;
    bound_rd_q <= bound_q[idx_q];
    if (match) begin
      hit_idx_q <= rd_idx_q;
    end
    if (cmd_i.commit) begin
      result_q <= result_d;
    end
  end

  // Owner memory: one scan read port, one write port
  always_ff @(posedge clk_i) begin
    owner_rd_q <= owner_mem[idx_q];
    if (cmd_i.commit && do_bind) begin
      owner_mem[pop_slot] <= req_q.segment_id;
    end
  end

  // Free stack memory: top read port, push write port
  always_ff @(posedge clk_i) begin
    stack_rd_q <= stack_mem[top_m1];
    if (cmd_i.commit && do_push) begin
      stack_mem[free_top_q[IdxW-1:0]] <= hit_idx_q;
    end
  end

  assign sts_o.cmp_last = rd_last_q;
  assign result_o       = result_q;
  assign done_o         = done_q;

`ifndef SYNTHESIS
  // Every slot is either on the free stack or bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, free_top_q} + {1'b0, count_q}) == (CntW + 1)'(POOL_SLOTS))
    else $error("free and used counts do not cover the pool");

  // A popped slot is never already bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && do_bind) |-> !bound_q[pop_slot])
    else $error("popped slot is already bound");

  // A hit always points at a bound slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && hit_q) |-> bound_q[hit_idx_q])
    else $error("hit slot is not bound");
`endif

endmodule

`default_nettype wire

/* hw/rtl/spa_ctrl.sv */
// Controller: state machine sequencing capture, owner scan and commit.
`default_nettype none

module spa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire spa_pkg::ctrl_sts_t sts_i,
  output spa_pkg::ctrl_cmd_t      cmd_o,
  output logic                    busy_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.cmp_last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  // Commit returns to idle in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |=> (state_q == S_IDLE))
    else $error("commit not followed by idle");

  // The last compare only happens while scanning.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.cmp_last |-> (state_q == S_SCAN))
    else $error("scan finished outside scan state");

  // A request is taken only when idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> (state_q == S_SCAN))
    else $error("request not followed by scan");
`endif

endmodule

`default_nettype wire

/* hw/rtl/segment_pool_allocator.sv */
// Top level: segment pool allocator, controller plus datapath.
// A request runs through capture, a scan of every owner entry and commit; the
//   result strobe is registered from commit. No new request is taken until commit
//   ends; the scan reads one slot owner per cycle from the owner memory's scan read port.
// Reset: async active low; free stack full (highest slot on top), no slot bound,
//   default segment size 1048576. No clearing pass; the receiver cannot stall.
`default_nettype none

module segment_pool_allocator #(
  parameter int unsigned POOL_SLOTS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Configuration: default segment length
  input  wire logic             cfg_we_i,
  input  wire logic [31:0]      cfg_wdata_i,
  // Request transfer: taken when start_i is high and busy_o low
  input  wire logic             start_i,
  input  wire spa_pkg::req_t    req_i,
  output logic                  busy_o,
  // Result transfer: valid for exactly the cycle done_o is high
  output logic                  done_o,
  output spa_pkg::result_t      result_o
);

  spa_pkg::ctrl_cmd_t cmd;
  spa_pkg::ctrl_sts_t sts;

  // Sequence idle -> scan all owners -> commit; hold busy until commit ends.
  spa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Hold pool state; scan owners for the id, then pop or push in the commit
  // state and register the result for a single-cycle strobe.
  spa_datapath #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o),
    .done_o      (done_o)
  );

endmodule

`default_nettype wire
